// ===== hdl/ftm_pkg.sv =====
// ftm_pkg: shared types and constants for the flector to matrix converter
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package ftm_pkg;

    // mode bit that selects the forward or the inverse matrix
    typedef logic t_mode;

    localparam t_mode MODE_FORWARD = 1'b0;
    localparam t_mode MODE_INVERSE = 1'b1;

endpackage : ftm_pkg

`default_nettype wire

// ===== hdl/ftm_in_if.sv =====
// ftm_in_if: request channel carrying one flector (plane part, point part, mode)
// depends on ftm_pkg for the mode type
`default_nettype none

interface ftm_in_if
    import ftm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  plane_x;
    logic signed [DATA_WIDTH-1:0]  plane_y;
    logic signed [DATA_WIDTH-1:0]  plane_z;
    logic signed [DATA_WIDTH-1:0]  plane_w;
    logic signed [DATA_WIDTH-1:0]  point_x;
    logic signed [DATA_WIDTH-1:0]  point_y;
    logic signed [DATA_WIDTH-1:0]  point_z;
    logic signed [DATA_WIDTH-1:0]  point_w;
    t_mode                         inverse_mode;

    modport source (
        output valid, plane_x, plane_y, plane_z, plane_w,
               point_x, point_y, point_z, point_w, inverse_mode,
        input  ready
    );

    modport sink (
        input  valid, plane_x, plane_y, plane_z, plane_w,
               point_x, point_y, point_z, point_w, inverse_mode,
        output ready
    );
endinterface : ftm_in_if

`default_nettype wire

// ===== hdl/ftm_out_if.sv =====
// ftm_out_if: result channel carrying one 3x4 affine matrix
// depends on ftm_pkg (shared project types)
`default_nettype none

interface ftm_out_if
    import ftm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  rot00;
    logic signed [DATA_WIDTH-1:0]  rot01;
    logic signed [DATA_WIDTH-1:0]  rot02;
    logic signed [DATA_WIDTH-1:0]  shift0;
    logic signed [DATA_WIDTH-1:0]  rot10;
    logic signed [DATA_WIDTH-1:0]  rot11;
    logic signed [DATA_WIDTH-1:0]  rot12;
    logic signed [DATA_WIDTH-1:0]  shift1;
    logic signed [DATA_WIDTH-1:0]  rot20;
    logic signed [DATA_WIDTH-1:0]  rot21;
    logic signed [DATA_WIDTH-1:0]  rot22;
    logic signed [DATA_WIDTH-1:0]  shift2;

    modport source (
        output valid, rot00, rot01, rot02, shift0, rot10, rot11, rot12, shift1,
               rot20, rot21, rot22, shift2,
        input  ready
    );

    modport sink (
        input  valid, rot00, rot01, rot02, shift0, rot10, rot11, rot12, shift1,
               rot20, rot21, rot22, shift2,
        output ready
    );
endinterface : ftm_out_if

`default_nettype wire

// ===== hdl/flector_to_matrix.sv =====
// flector_to_matrix: converts a flector into its 3x4 affine matrix, fixed point
// depends on ftm_pkg, ftm_in_if and ftm_out_if
// pipeline: input, product and result registers in that order, from request acceptance to result valid
// throughput: one request per cycle while o_matrix.ready holds; each pipeline stage refills while the next one drains
// the product register stage (21 parallel multipliers with rounding) sets the cycle time
// reset: synchronous, active low; clears the stage valid bits only, no state otherwise
`default_nettype none

module flector_to_matrix
    import ftm_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ftm_in_if.sink     i_flector,
    ftm_out_if.source  o_matrix
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
    localparam int ACC_W  = RND_W + 4;

    localparam logic signed [PROD_W:0]    HALF_LSB = (PROD_W + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]   ONE_ACC  = ACC_W'(1) <<< FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0]     SAT_MAX  = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0]     SAT_MIN  = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    // exact product rounded half up to FRAC_BITS fraction bits
    function automatic logic signed [RND_W-1:0] mul_rnd(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W:0]   s;
        p = PROD_W'(a) * PROD_W'(b);
        s = (PROD_W + 1)'(p) + HALF_LSB;
        return RND_W'(s >>> FRAC_BITS);
    endfunction

    // clamp a wide sum to the output range
    function automatic logic [DATA_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:DATA_WIDTH-1]) | ~(|v[ACC_W-1:DATA_WIDTH-1]);
        if (fits) begin
            return v[DATA_WIDTH-1:0];
        end else if (v[ACC_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    // sign extension of a rounded product into the accumulator width
    function automatic logic signed [ACC_W-1:0] ext(input logic signed [RND_W-1:0] v);
        return ACC_W'(v);
    endfunction

    // pipeline flow control: a stage loads when empty or when it drains
    logic r_v1, r_v2, r_v3;
    logic load1, load2, load3;

    assign load3 = !r_v3 || o_matrix.ready;
    assign load2 = !r_v2 || load3;
    assign load1 = !r_v1 || load2;
    assign i_flector.ready = load1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= i_flector.valid;
            end
            if (load2) begin
                r_v2 <= r_v1;
            end
            if (load3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // input register
    logic signed [DATA_WIDTH-1:0] r_gx, r_gy, r_gz, r_gw, r_px, r_py, r_pz, r_pw;
    t_mode                        r_mode1;

    always_ff @(posedge i_clk) begin
        if (load1 && i_flector.valid) begin
            r_gx    <= i_flector.plane_x;
            r_gy    <= i_flector.plane_y;
            r_gz    <= i_flector.plane_z;
            r_gw    <= i_flector.plane_w;
            r_px    <= i_flector.point_x;
            r_py    <= i_flector.point_y;
            r_pz    <= i_flector.point_z;
            r_pw    <= i_flector.point_w;
            r_mode1 <= i_flector.inverse_mode;
        end
    end

    // product register: squares, plane cross terms, weight terms, cross products
    logic signed [RND_W-1:0] r_sx, r_sy, r_sz, r_gxy, r_gzx, r_gyz;
    logic signed [RND_W-1:0] r_pxw, r_pyw, r_pzw, r_gxw, r_gyw, r_gzw;
    logic signed [RND_W-1:0] r_gzpw, r_gypw, r_gxpw;
    logic signed [RND_W-1:0] r_gypz, r_gzpy, r_gzpx, r_gxpz, r_gxpy, r_gypx;
    t_mode                   r_mode2;

    always_ff @(posedge i_clk) begin
        if (load2 && r_v1) begin
            r_sx    <= mul_rnd(r_gx, r_gx);
            r_sy    <= mul_rnd(r_gy, r_gy);
            r_sz    <= mul_rnd(r_gz, r_gz);
            r_gxy   <= mul_rnd(r_gx, r_gy);
            r_gzx   <= mul_rnd(r_gz, r_gx);
            r_gyz   <= mul_rnd(r_gy, r_gz);
            r_pxw   <= mul_rnd(r_px, r_pw);
            r_pyw   <= mul_rnd(r_py, r_pw);
            r_pzw   <= mul_rnd(r_pz, r_pw);
            r_gxw   <= mul_rnd(r_gx, r_gw);
            r_gyw   <= mul_rnd(r_gy, r_gw);
            r_gzw   <= mul_rnd(r_gz, r_gw);
            r_gzpw  <= mul_rnd(r_gz, r_pw);
            r_gypw  <= mul_rnd(r_gy, r_pw);
            r_gxpw  <= mul_rnd(r_gx, r_pw);
            r_gypz  <= mul_rnd(r_gy, r_pz);
            r_gzpy  <= mul_rnd(r_gz, r_py);
            r_gzpx  <= mul_rnd(r_gz, r_px);
            r_gxpz  <= mul_rnd(r_gx, r_pz);
            r_gxpy  <= mul_rnd(r_gx, r_py);
            r_gypx  <= mul_rnd(r_gy, r_px);
            r_mode2 <= r_mode1;
        end
    end

    // matrix assembly: sums, doublings, mode sign flips, saturation
    logic signed [ACC_W-1:0] s01, s02, s12, k01, k20, k12, c0, c1, c2, t0, t1, t2;
    logic                    inv;
    logic [DATA_WIDTH-1:0]   n_rot00, n_rot01, n_rot02, n_shift0;
    logic [DATA_WIDTH-1:0]   n_rot10, n_rot11, n_rot12, n_shift1;
    logic [DATA_WIDTH-1:0]   n_rot20, n_rot21, n_rot22, n_shift2;

    always_comb begin
        inv = (r_mode2 == MODE_INVERSE);
        s01 = -(ext(r_gxy) <<< 1);
        s02 = -(ext(r_gzx) <<< 1);
        s12 = -(ext(r_gyz) <<< 1);
        k01 = inv ? -(ext(r_gzpw) <<< 1) : (ext(r_gzpw) <<< 1);
        k20 = inv ? -(ext(r_gypw) <<< 1) : (ext(r_gypw) <<< 1);
        k12 = inv ? -(ext(r_gxpw) <<< 1) : (ext(r_gxpw) <<< 1);
        c0  = inv ? (ext(r_gzpy) - ext(r_gypz)) : (ext(r_gypz) - ext(r_gzpy));
        c1  = inv ? (ext(r_gxpz) - ext(r_gzpx)) : (ext(r_gzpx) - ext(r_gxpz));
        c2  = inv ? (ext(r_gypx) - ext(r_gxpy)) : (ext(r_gxpy) - ext(r_gypx));
        t0  = ext(r_pxw) - ext(r_gxw);
        t1  = ext(r_pyw) - ext(r_gyw);
        t2  = ext(r_pzw) - ext(r_gzw);

        n_rot00  = sat(((ext(r_sy) + ext(r_sz)) <<< 1) - ONE_ACC);
        n_rot01  = sat(s01 + k01);
        n_rot02  = sat(s02 - k20);
        n_shift0 = sat((t0 + c0) <<< 1);
        n_rot10  = sat(s01 - k01);
        n_rot11  = sat(((ext(r_sz) + ext(r_sx)) <<< 1) - ONE_ACC);
        n_rot12  = sat(s12 + k12);
        n_shift1 = sat((t1 + c1) <<< 1);
        n_rot20  = sat(s02 + k20);
        n_rot21  = sat(s12 - k12);
        n_rot22  = sat(((ext(r_sx) + ext(r_sy)) <<< 1) - ONE_ACC);
        n_shift2 = sat((t2 + c2) <<< 1);
    end

    // result register
    logic [DATA_WIDTH-1:0] r_rot00, r_rot01, r_rot02, r_shift0;
    logic [DATA_WIDTH-1:0] r_rot10, r_rot11, r_rot12, r_shift1;
    logic [DATA_WIDTH-1:0] r_rot20, r_rot21, r_rot22, r_shift2;

    always_ff @(posedge i_clk) begin
        if (load3 && r_v2) begin
            r_rot00  <= n_rot00;
            r_rot01  <= n_rot01;
            r_rot02  <= n_rot02;
            r_shift0 <= n_shift0;
            r_rot10  <= n_rot10;
            r_rot11  <= n_rot11;
            r_rot12  <= n_rot12;
            r_shift1 <= n_shift1;
            r_rot20  <= n_rot20;
            r_rot21  <= n_rot21;
            r_rot22  <= n_rot22;
            r_shift2 <= n_shift2;
        end
    end

    // output channel
    assign o_matrix.valid  = r_v3;
    assign o_matrix.rot00  = r_rot00;
    assign o_matrix.rot01  = r_rot01;
    assign o_matrix.rot02  = r_rot02;
    assign o_matrix.shift0 = r_shift0;
    assign o_matrix.rot10  = r_rot10;
    assign o_matrix.rot11  = r_rot11;
    assign o_matrix.rot12  = r_rot12;
    assign o_matrix.shift1 = r_shift1;
    assign o_matrix.rot20  = r_rot20;
    assign o_matrix.rot21  = r_rot21;
    assign o_matrix.rot22  = r_rot22;
    assign o_matrix.shift2 = r_shift2;

`ifndef SYNTHESIS
    // a full input stage moves on whenever the product stage loads
    a_stage1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && load2 |=> r_v2)
        else $error("input stage item lost on its way to the product stage");

    // a full product stage moves on whenever the result stage loads
    a_stage2_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && load3 |=> r_v3)
        else $error("product stage item lost on its way to the result stage");

    // back pressure reaches the input only with every stage full and the sink stalled
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_flector.ready |-> r_v1 && r_v2 && r_v3 && !o_matrix.ready)
        else $error("input stalled while the pipeline has room");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v3)
        else $error("result valid right after reset");
`endif

endmodule : flector_to_matrix

`default_nettype wire

// ===== tb/flector_to_matrix_test.sv =====
// flector_to_matrix_test: self-checking testbench for the flector to matrix converter
// depends on ftm_pkg, ftm_in_if, ftm_out_if and flector_to_matrix
// directed table then random flectors, checked against typed matrices or a fixed point predictor
`timescale 1ns / 1ps

module flector_to_matrix_test;
    import ftm_pkg::*;

    localparam int DW            = 32;
    localparam int FRAC_BITS     = 16;
    localparam int CLK_PERIOD    = 8;
    localparam int LATENCY       = 3;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int QUIET_ITEMS   = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [DW-1:0] Q_ZERO    = 32'sh0000_0000;
    localparam logic signed [DW-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [DW-1:0] Q_NEG_ONE = 32'shFFFF_0000;
    localparam logic signed [DW-1:0] Q_HALF    = 32'sh0000_8000;
    localparam logic signed [DW-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] Q_MIN     = 32'sh8000_0000;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [DW-1:0] plane_x;
        logic signed [DW-1:0] plane_y;
        logic signed [DW-1:0] plane_z;
        logic signed [DW-1:0] plane_w;
        logic signed [DW-1:0] point_x;
        logic signed [DW-1:0] point_y;
        logic signed [DW-1:0] point_z;
        logic signed [DW-1:0] point_w;
        t_mode                inverse_mode;
    } t_flector;

    typedef struct packed {
        logic signed [DW-1:0] rot00;
        logic signed [DW-1:0] rot01;
        logic signed [DW-1:0] rot02;
        logic signed [DW-1:0] shift0;
        logic signed [DW-1:0] rot10;
        logic signed [DW-1:0] rot11;
        logic signed [DW-1:0] rot12;
        logic signed [DW-1:0] shift1;
        logic signed [DW-1:0] rot20;
        logic signed [DW-1:0] rot21;
        logic signed [DW-1:0] rot22;
        logic signed [DW-1:0] shift2;
    } t_matrix;

    typedef struct {
        t_flector flector;
        bit       typed;
        t_matrix  matrix;
    } t_stimulus_row;

    string entry_names [12] = '{"rot00", "rot01", "rot02", "shift0", "rot10", "rot11",
                                "rot12", "shift1", "rot20", "rot21", "rot22", "shift2"};

    logic i_clk = 1'b0;
    logic i_rst_n;

    ftm_in_if  #(.DATA_WIDTH(DW)) flector_bus ();
    ftm_out_if #(.DATA_WIDTH(DW)) matrix_bus ();

    flector_to_matrix #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flector(flector_bus),
        .o_matrix (matrix_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_matrix         expected_matrices [$];
    t_stimulus_row   directed_rows [$];
    int              error_count  = 0;
    int              stall_cycles = 0;
    bit              quiet_tail   = 1'b0;

    // exact product rounded half up to the fraction width
    function automatic longint rounded_product(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b);
        longint full;
        full = longint'(a) * longint'(b);
        return (full + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [DW-1:0] saturate_entry(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[DW-1:0];
    endfunction

    // affine matrix of one flector
    function automatic t_matrix predict_matrix(input t_flector f);
        longint sq_x, sq_y, sq_z, diag0, diag1, diag2, sym01, sym02, sym12;
        longint tr0, tr1, tr2, wz, wy, wx, cr0, cr1, cr2;
        t_matrix m;
        sq_x  = rounded_product(f.plane_x, f.plane_x);
        sq_y  = rounded_product(f.plane_y, f.plane_y);
        sq_z  = rounded_product(f.plane_z, f.plane_z);
        diag0 = 2 * (sq_y + sq_z) - longint'(Q_ONE);
        diag1 = 2 * (sq_z + sq_x) - longint'(Q_ONE);
        diag2 = 2 * (sq_x + sq_y) - longint'(Q_ONE);
        sym01 = -2 * rounded_product(f.plane_x, f.plane_y);
        sym02 = -2 * rounded_product(f.plane_z, f.plane_x);
        sym12 = -2 * rounded_product(f.plane_y, f.plane_z);
        tr0 = rounded_product(f.point_x, f.point_w) - rounded_product(f.plane_x, f.plane_w);
        tr1 = rounded_product(f.point_y, f.point_w) - rounded_product(f.plane_y, f.plane_w);
        tr2 = rounded_product(f.point_z, f.point_w) - rounded_product(f.plane_z, f.plane_w);
        wz  = 2 * rounded_product(f.plane_z, f.point_w);
        wy  = 2 * rounded_product(f.plane_y, f.point_w);
        wx  = 2 * rounded_product(f.plane_x, f.point_w);
        cr0 = rounded_product(f.plane_y, f.point_z) - rounded_product(f.plane_z, f.point_y);
        cr1 = rounded_product(f.plane_z, f.point_x) - rounded_product(f.plane_x, f.point_z);
        cr2 = rounded_product(f.plane_x, f.point_y) - rounded_product(f.plane_y, f.point_x);
        // inverse flips every antisymmetric contribution
        if (f.inverse_mode == MODE_INVERSE) begin
            wz  = -wz;  wy  = -wy;  wx  = -wx;
            cr0 = -cr0; cr1 = -cr1; cr2 = -cr2;
        end
        m.rot00  = saturate_entry(diag0);
        m.rot01  = saturate_entry(sym01 + wz);
        m.rot02  = saturate_entry(sym02 - wy);
        m.shift0 = saturate_entry(2 * (tr0 + cr0));
        m.rot10  = saturate_entry(sym01 - wz);
        m.rot11  = saturate_entry(diag1);
        m.rot12  = saturate_entry(sym12 + wx);
        m.shift1 = saturate_entry(2 * (tr1 + cr1));
        m.rot20  = saturate_entry(sym02 + wy);
        m.rot21  = saturate_entry(sym12 - wx);
        m.rot22  = saturate_entry(diag2);
        m.shift2 = saturate_entry(2 * (tr2 + cr2));
        return m;
    endfunction

    function automatic t_flector make_flector(
        input logic signed [DW-1:0] gx, gy, gz, gw, px, py, pz, pw,
        input t_mode mode
    );
        t_flector f;
        f.plane_x = gx; f.plane_y = gy; f.plane_z = gz; f.plane_w = gw;
        f.point_x = px; f.point_y = py; f.point_z = pz; f.point_w = pw;
        f.inverse_mode = mode;
        return f;
    endfunction

    function automatic t_matrix make_matrix(
        input logic signed [DW-1:0] r00, r01, r02, s0, r10, r11, r12, s1,
        input logic signed [DW-1:0] r20, r21, r22, s2
    );
        t_matrix m;
        m.rot00 = r00; m.rot01 = r01; m.rot02 = r02; m.shift0 = s0;
        m.rot10 = r10; m.rot11 = r11; m.rot12 = r12; m.shift1 = s1;
        m.rot20 = r20; m.rot21 = r21; m.rot22 = r22; m.shift2 = s2;
        return m;
    endfunction

    task automatic add_row(input t_flector f, input bit typed, input t_matrix m);
        t_stimulus_row row;
        row.flector = f;
        row.typed   = typed;
        row.matrix  = m;
        directed_rows.push_back(row);
    endtask

    // mix of small values, full range words and corner values
    function automatic logic signed [DW-1:0] random_component();
        logic signed [DW-1:0] corners [8] = '{Q_ZERO, Q_MAX, Q_MIN, Q_ONE, Q_NEG_ONE,
                                              Q_HALF, 32'sd1, -32'sd1};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            8, 9:       return corners[$urandom_range(0, 7)];
            default:    return $urandom;
        endcase
    endfunction

    // present one request and hold it until accepted
    task automatic send_flector(input t_flector f, input bit typed, input t_matrix m);
        flector_bus.valid        <= 1'b1;
        flector_bus.plane_x      <= f.plane_x;
        flector_bus.plane_y      <= f.plane_y;
        flector_bus.plane_z      <= f.plane_z;
        flector_bus.plane_w      <= f.plane_w;
        flector_bus.point_x      <= f.point_x;
        flector_bus.point_y      <= f.point_y;
        flector_bus.point_z      <= f.point_z;
        flector_bus.point_w      <= f.point_w;
        flector_bus.inverse_mode <= f.inverse_mode;
        @(posedge i_clk);
        while (flector_bus.ready !== 1'b1) @(posedge i_clk);
        expected_matrices.push_back(typed ? m : predict_matrix(f));
    endtask

    // random gap on the request side
    task automatic maybe_idle_sender();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            flector_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic check_matrix(input t_matrix got);
        t_matrix want;
        logic signed [DW-1:0] want_entry, got_entry;
        if (expected_matrices.size() == 0) begin
            if (error_count < REPORT_LIMIT)
                $display("unexpected matrix %h", got);
            error_count++;
        end else begin
            want = expected_matrices.pop_front();
            for (int i = 0; i < 12; i++) begin
                want_entry = want[(11 - i) * DW +: DW];
                got_entry  = got[(11 - i) * DW +: DW];
                if (want_entry !== got_entry) begin
                    if (error_count < REPORT_LIMIT)
                        $display("mismatch %s: expected %h got %h",
                                 entry_names[i], want_entry, got_entry);
                    error_count++;
                end
            end
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && matrix_bus.valid === 1'b1 && matrix_bus.ready === 1'b1) begin
            check_matrix(make_matrix(
                matrix_bus.rot00, matrix_bus.rot01, matrix_bus.rot02, matrix_bus.shift0,
                matrix_bus.rot10, matrix_bus.rot11, matrix_bus.rot12, matrix_bus.shift1,
                matrix_bus.rot20, matrix_bus.rot21, matrix_bus.rot22, matrix_bus.shift2));
        end
    end

    // cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((flector_bus.valid === 1'b1 && flector_bus.ready === 1'b1) ||
            (matrix_bus.valid === 1'b1 && matrix_bus.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // result side backpressure in random bursts
    initial begin
        matrix_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            matrix_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!quiet_tail) begin
                matrix_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        t_flector f;
        i_rst_n                  <= 1'b0;
        flector_bus.valid        <= 1'b0;
        flector_bus.plane_x      <= '0;
        flector_bus.plane_y      <= '0;
        flector_bus.plane_z      <= '0;
        flector_bus.plane_w      <= '0;
        flector_bus.point_x      <= '0;
        flector_bus.point_y      <= '0;
        flector_bus.point_z      <= '0;
        flector_bus.point_w      <= '0;
        flector_bus.inverse_mode <= MODE_FORWARD;

        // zero flector gives minus one on the diagonal
        add_row(make_flector(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                             MODE_FORWARD), 1'b1,
                make_matrix(Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_ZERO,
                            Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_ZERO));
        add_row(make_flector(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                             MODE_INVERSE), 1'b1,
                make_matrix(Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_ZERO,
                            Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_ZERO));
        // reflection through the x plane
        add_row(make_flector(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                             MODE_FORWARD), 1'b1,
                make_matrix(Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO,
                            Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
        // all components at the top or bottom: saturation, antisymmetric terms cancel
        add_row(make_flector(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                             MODE_FORWARD), 1'b1,
                make_matrix(Q_MAX, Q_ZERO, Q_MIN, Q_ZERO, Q_MIN, Q_MAX, Q_ZERO,
                            Q_ZERO, Q_ZERO, Q_MIN, Q_MAX, Q_ZERO));
        add_row(make_flector(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                             MODE_FORWARD), 1'b1,
                make_matrix(Q_MAX, Q_ZERO, Q_MIN, Q_ZERO, Q_MIN, Q_MAX, Q_ZERO,
                            Q_ZERO, Q_ZERO, Q_MIN, Q_MAX, Q_ZERO));
        add_row(make_flector(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                             MODE_INVERSE), 1'b0, '0);
        add_row(make_flector(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                             MODE_INVERSE), 1'b0, '0);
        add_row(make_flector(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                             MODE_FORWARD), 1'b0, '0);
        add_row(make_flector(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                             MODE_INVERSE), 1'b0, '0);
        // rounding exactly at one half lsb, both signs
        add_row(make_flector(32'sd1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF,
                             MODE_FORWARD), 1'b0, '0);
        add_row(make_flector(-32'sd1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF,
                             MODE_INVERSE), 1'b0, '0);
        add_row(make_flector(Q_HALF, -Q_HALF, Q_HALF, -32'sd1, 32'sd1, Q_HALF, -Q_HALF, Q_HALF,
                             MODE_FORWARD), 1'b0, '0);
        // unit normal with offset, and a point part alone
        add_row(make_flector(32'sh0000_9999, 32'sh0000_CCCC, Q_ZERO, 32'sh0002_0000,
                             32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, Q_ONE,
                             MODE_FORWARD), 1'b0, '0);
        add_row(make_flector(32'sh0000_9999, 32'sh0000_CCCC, Q_ZERO, 32'sh0002_0000,
                             32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, Q_ONE,
                             MODE_INVERSE), 1'b0, '0);
        add_row(make_flector(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, -32'sh0005_0000, 32'sh0007_8000,
                             Q_MAX, Q_ONE, MODE_FORWARD), 1'b0, '0);
        // alternating bit patterns
        add_row(make_flector(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                             32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                             MODE_FORWARD), 1'b0, '0);
        add_row(make_flector(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                             32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                             MODE_INVERSE), 1'b0, '0);
        add_row(make_flector(Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX,
                             MODE_INVERSE), 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            maybe_idle_sender();
            send_flector(directed_rows[i].flector, directed_rows[i].typed,
                         directed_rows[i].matrix);
        end

        // random flectors
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            // hold off until the pipeline has fully drained
            if (n == RANDOM_ITEMS / 3 || n == (2 * RANDOM_ITEMS) / 3) begin
                flector_bus.valid <= 1'b0;
                @(posedge i_clk);
                while (expected_matrices.size() != 0) @(posedge i_clk);
            end else begin
                maybe_idle_sender();
            end
            f = make_flector(random_component(), random_component(), random_component(),
                             random_component(), random_component(), random_component(),
                             random_component(), random_component(),
                             $urandom_range(0, 1) ? MODE_INVERSE : MODE_FORWARD);
            send_flector(f, 1'b0, '0);
        end
        flector_bus.valid <= 1'b0;

        // drain and let the pipeline settle
        while (expected_matrices.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        error_count += expected_matrices.size();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule : flector_to_matrix_test
